@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the thinning pass RTL.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge.
`define ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent implies consequent at the same edge.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent at the next edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/tsp_pkg.sv @@
// Package for the thinning subiteration pass: types, register codes, constants
// and the Zhang-Suen removal test. No dependencies.
`timescale 1ns / 1ps

package tsp_pkg;

	localparam int TSP_MAX_WIDTH   = 1024;
	localparam int WIDTH_REG_W     = 11;
	localparam int HEIGHT_REG_W    = 16;
	localparam int CFG_DATA_W      = 16;
	localparam int CFG_INDEX_W     = 2;
	localparam int PIXEL_W         = 8;
	localparam int ROW_W           = 16;
	localparam int COL_W           = 10;
	localparam int OUT_TDATA_W     = 40;
	localparam int OUT_TUSER_W     = 2;
	localparam int MIN_DIM         = 3;

	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd1024;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd768;

	localparam logic [PIXEL_W-1:0] PIX_FG = 8'd0;
	localparam logic [PIXEL_W-1:0] PIX_BG = 8'd255;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_PASS_KIND    = 2'd2
	} tsp_reg_t;

	// Pixel as it waits in the first stage, with the decisions taken at accept time.
	typedef struct packed {
		logic              fg;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic              interior;
		logic              border;
		logic              corner;
		logic              frame_start;
	} tsp_item_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] pixel;
		logic [ROW_W-1:0]   row;
		logic [COL_W-1:0]   col;
		logic               last_of_run;
		logic               frame_end;
		logic               any_removed;
	} tsp_result_t;

	// nb: P2..P9 in bits 0..7, 1 = foreground.
	function automatic logic tsp_remove(input logic [7:0] nb, input logic pass_kind);
		logic [3:0] cnt;
		logic [3:0] trans;
		logic       pass_ok;
		cnt   = '0;
		trans = '0;
		for (int k = 0; k < 8; k++) begin
			cnt = cnt + {3'b000, nb[k]};
			if (!nb[k] && nb[3'(k + 1)])
				trans = trans + 4'd1;
		end
		if (pass_kind)
			pass_ok = !(nb[0] && nb[2] && nb[6]) && !(nb[0] && nb[4] && nb[6]);
		else
			pass_ok = !(nb[0] && nb[2] && nb[4]) && !(nb[2] && nb[4] && nb[6]);
		return (cnt >= 4'd2) && (cnt <= 4'd6) && (trans == 4'd1) && pass_ok;
	endfunction

endpackage

@@ rtl/core/tsp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tsp_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/core/tsp_eval.sv @@
// Window evaluation: 3x3 neighborhood, removal decision and the removed flag.
// Depends on tsp_pkg.
`timescale 1ns / 1ps

module tsp_eval
	import tsp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  logic        pass_kind,
	input  tsp_item_t   item,
	input  logic [1:0]  col_bits,   // bit 0 top row, bit 1 middle row
	output logic [1:0]  wr_bits,
	output tsp_result_t res0,
	output tsp_result_t res1,
	output logic [1:0]  res_count
);

	// bits 0..2 column c-2 (top, mid, bot), bits 3..5 column c-1
	logic [5:0] window_q;
	logic       removed_q;

	logic       top;
	logic       mid;
	logic       bot;
	logic [7:0] nb;
	logic       centre;
	logic       remove;
	logic       removed_next;
	tsp_result_t int_res;
	tsp_result_t bord_res;

	assign top    = col_bits[0];
	assign mid    = col_bits[1];
	assign bot    = item.fg;
	assign centre = window_q[4];

	assign nb = {window_q[0], window_q[1], window_q[2], window_q[5],
	             bot, mid, top, window_q[3]};

	assign remove = item.interior && centre && tsp_remove(nb, pass_kind);

	assign removed_next = (item.frame_start ? 1'b0 : removed_q) | remove;

	assign wr_bits = {bot, mid};

	always_comb begin
		int_res             = '0;
		int_res.pixel       = (centre && !remove) ? PIX_FG : PIX_BG;
		int_res.row         = item.row - ROW_W'(1);
		int_res.col         = item.col - COL_W'(1);
		int_res.last_of_run = !item.border;
		int_res.any_removed = removed_next;

		bord_res             = '0;
		bord_res.pixel       = item.fg ? PIX_FG : PIX_BG;
		bord_res.row         = item.row;
		bord_res.col         = item.col;
		bord_res.last_of_run = 1'b1;
		bord_res.frame_end   = item.corner;
		bord_res.any_removed = removed_next;
	end

	// interior result goes first when both are present
	assign res0      = item.interior ? int_res : bord_res;
	assign res1      = bord_res;
	assign res_count = {1'b0, item.interior} + {1'b0, item.border};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q  <= '0;
			removed_q <= 1'b0;
		end else if (advance) begin
			window_q  <= {bot, mid, top, window_q[5:3]};
			removed_q <= removed_next;
		end
	end

endmodule

@@ rtl/core/tsp_outq.sv @@
// Two-entry result buffer driving the master stream.
// Depends on tsp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tsp_outq
	import tsp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  logic [1:0]             load_count,
	input  tsp_result_t            load_res0,
	input  tsp_result_t            load_res1,
	output logic                   load_ok,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // pixel_out, out_row, out_col, zero pad
	output logic                   m_tlast,  // last_of_run
	output logic [OUT_TUSER_W-1:0] m_tuser   // frame_end, any_removed
);

	tsp_result_t res0_q;
	tsp_result_t res1_q;
	logic [1:0]  cnt_q;
	logic        pop;

	assign pop      = m_tvalid && m_tready;
	assign load_ok  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && m_tready);
	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = {{(OUT_TDATA_W - PIXEL_W - ROW_W - COL_W){1'b0}},
	                   res0_q.col, res0_q.row, res0_q.pixel};
	assign m_tlast  = res0_q.last_of_run;
	assign m_tuser  = {res0_q.any_removed, res0_q.frame_end};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= load_count;
		end else if (pop) begin
			cnt_q <= (cnt_q == 2'd2) ? 2'd1 : 2'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res0_q <= load_res0;
			res1_q <= load_res1;
		end else if (pop && cnt_q == 2'd2) begin
			res0_q <= res1_q;
		end
	end

	`ASSERT_ALWAYS(a_cnt_range, cnt_q != 2'd3, "result count out of range")
	`ASSERT_IMPL(a_pair_order, cnt_q == 2'd2, !res0_q.last_of_run, "first of pair marked last")
	`ASSERT_IMPL(a_frame_end_last, m_tvalid && m_tuser[0], m_tlast, "frame end not last of run")
	`ASSERT_IMPL(a_load_room, load, load_ok, "load into a full buffer")

endmodule

@@ rtl/core/thinning_subiteration_pass_unit.sv @@
// One Zhang-Suen thinning subiteration over a raster pixel stream (0 = foreground).
// Depends on tsp_pkg, tsp_ram, tsp_eval, tsp_outq and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// The unit takes one pixel per clock while the output buffer has room. Each
// pixel is registered together with its line-store read, judged in the
// following cycle against the 3x3 window, and handed to a two-entry output
// buffer. A pixel that yields both an interior and a border result (last
// column from row 2 on, or columns 2 and up of the last row) loads two
// results into the buffer, so even under a stream with no back-pressure the
// input pauses after such a pixel. After reset the line store is cleared one
// entry per cycle over all MAX_WIDTH entries, during which s_tready stays
// low; configuration writes are taken at any time.
module thinning_subiteration_pass_unit
	import tsp_pkg::*;
#(
	parameter int MAX_WIDTH = TSP_MAX_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [PIXEL_W-1:0]     s_tdata,  // pixel_in
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // pixel_out, out_row, out_col, zero pad
	output logic                   m_tlast,  // last_of_run
	output logic [OUT_TUSER_W-1:0] m_tuser   // frame_end, any_removed
);

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int CMPW = (CW + 1 > WIDTH_REG_W) ? CW + 1 : WIDTH_REG_W;

	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic                    pass_q;

	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic             clr_q;
	logic [CW-1:0]    clr_addr_q;

	logic             valid_s1;
	tsp_item_t        item_s1;
	logic [CW-1:0]    idx_s1;

	logic [CMPW-1:0]  w_ext;
	logic [CMPW-1:0]  wl_ext;
	logic [CW-1:0]    wl;
	logic [ROW_W-1:0] hl;
	logic [CW-1:0]    c;
	logic             last_col;
	logic             last_row;
	logic             accept;
	logic             s1_adv;
	tsp_item_t        item_d;

	logic [1:0]  col_bits;
	logic [1:0]  wr_bits;
	tsp_result_t res0;
	tsp_result_t res1;
	logic [1:0]  res_count;
	logic        load_ok;

	// clamp the frame size
	assign w_ext  = CMPW'(width_q);
	assign wl_ext = (w_ext < CMPW'(MIN_DIM))   ? CMPW'(MIN_DIM - 1) :
	                (w_ext > CMPW'(MAX_WIDTH)) ? CMPW'(MAX_WIDTH - 1) :
	                                             w_ext - CMPW'(1);
	assign wl     = CW'(wl_ext);
	assign hl     = (height_q < HEIGHT_REG_W'(MIN_DIM)) ? ROW_W'(MIN_DIM - 1) :
	                                                      height_q - ROW_W'(1);

	assign c        = (col_q > wl) ? wl : col_q;
	assign last_col = (c == wl);
	assign last_row = (row_q >= hl);

	always_comb begin
		item_d             = '0;
		item_d.fg          = (s_tdata == PIX_FG);
		item_d.row         = row_q;
		item_d.col         = COL_W'(c);
		item_d.interior    = (row_q >= ROW_W'(2)) && (c >= CW'(2));
		item_d.border      = (row_q == '0) || last_row || (c == '0) || last_col;
		item_d.corner      = last_row && last_col;
		item_d.frame_start = (row_q == '0) && (c == '0);
	end

	assign s1_adv   = valid_s1 && ((res_count == 2'd0) || load_ok);
	assign s_tready = !clr_q && (!valid_s1 || s1_adv);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			pass_q   <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_wdata[WIDTH_REG_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_wdata[HEIGHT_REG_W-1:0];
				REG_PASS_KIND:    pass_q   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// sweep the line store once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + CW'(1);
			if (clr_addr_q == CW'(MAX_WIDTH - 1))
				clr_q <= 1'b0;
		end
	end

	// advance the raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= c + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (s1_adv)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
			idx_s1  <= c;
		end
	end

	tsp_ram #(
		.WIDTH (2),
		.DEPTH (MAX_WIDTH)
	) u_line_store (
		.clk   (clk),
		.we    (clr_q || s1_adv),
		.waddr (clr_q ? clr_addr_q : idx_s1),
		.wdata (clr_q ? 2'b00 : wr_bits),
		.re    (accept),
		.raddr (c),
		.rdata (col_bits)
	);

	tsp_eval u_eval (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (s1_adv),
		.pass_kind (pass_q),
		.item      (item_s1),
		.col_bits  (col_bits),
		.wr_bits   (wr_bits),
		.res0      (res0),
		.res1      (res1),
		.res_count (res_count)
	);

	tsp_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (s1_adv && (res_count != 2'd0)),
		.load_count (res_count),
		.load_res0  (res0),
		.load_res1  (res1),
		.load_ok    (load_ok),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

	`ASSERT_IMPL(a_clear_blocks_input, clr_q, !s_tready, "input taken during line store clear")
	`ASSERT_NEXT(a_s1_hold, valid_s1 && !s1_adv, valid_s1 && $stable(idx_s1), "stalled pixel lost")
	`ASSERT_IMPL(a_col_in_range, valid_s1, idx_s1 <= CW'(MAX_WIDTH - 1), "column past line store")

endmodule

@@ dv/testbench.sv @@
// Testbench for thinning_subiteration_pass_unit: streams frames of pixels and checks
// each output transaction against a thinning predictor kept in step here or a directed table.
// Depends on tsp_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module testbench;
	import tsp_pkg::*;

	localparam int LIMIT_CYCLES  = 400000;
	localparam int RANDOM_ITEMS  = 790;
	localparam int HOLD_CYCLES   = 300;
	localparam int QUIET_CYCLES  = 12;
	localparam int WIDE_ITEMS    = 40;
	localparam int DIR_ROWS      = 18;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] pix;
		logic               typed;
		tsp_result_t        want;
	} dir_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_wr_en = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [PIXEL_W-1:0]     s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;  // pixel_out, out_row, out_col, zero pad
	logic                   m_tlast;  // last_of_run
	logic [OUT_TUSER_W-1:0] m_tuser;  // frame_end, any_removed

	// predictor state
	bit                line_mem [2*TSP_MAX_WIDTH];
	bit [5:0]          win_q;
	bit [ROW_W-1:0]    row_q;
	int                col_q;
	bit                removed_q;
	bit [10:0]         reg_width = WIDTH_RESET;
	bit [15:0]         reg_height = HEIGHT_RESET;
	bit                reg_pass;

	tsp_result_t pix_expect_q [$];
	dir_row_t    dir_tab [DIR_ROWS];
	int          mismatches;
	int          cycles;
	int          items_sent;
	int          tx_pct;
	int          rx_pct;
	int          frame_w;
	int          frame_h;
	bit          hold_arm;
	logic        rx_hold = 1'b0;

	thinning_subiteration_pass_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic tsp_result_t mk_res(input logic [7:0] pix, input logic [15:0] r,
			input logic [9:0] c, input logic last, input logic fend, input logic anyr);
		tsp_result_t t;
		t.pixel       = pix;
		t.row         = r;
		t.col         = c;
		t.last_of_run = last;
		t.frame_end   = fend;
		t.any_removed = anyr;
		return t;
	endfunction

	// nb holds P2..P9 in bits 0..7, 1 = foreground
	function automatic logic zs_removable(input logic [7:0] nb, input logic pk);
		int fg_cnt;
		int rises;
		fg_cnt = 0;
		rises  = 0;
		for (int k = 0; k < 8; k++) begin
			fg_cnt += int'(nb[k]);
			if (!nb[k] && nb[(k + 1) % 8])
				rises++;
		end
		if (fg_cnt < 2 || fg_cnt > 6 || rises != 1)
			return 1'b0;
		if (!pk)
			return !(nb[0] && nb[2] && nb[4]) && !(nb[2] && nb[4] && nb[6]);
		return !(nb[0] && nb[2] && nb[6]) && !(nb[0] && nb[4] && nb[6]);
	endfunction

	task automatic thin_predict(input logic [7:0] v, output tsp_result_t res [2], output int n);
		int         w;
		int         h;
		int         r;
		int         c;
		bit         last_c;
		bit         last_r;
		bit         fg;
		bit         top;
		bit         mid;
		bit [7:0]   nb;
		bit [7:0]   pix;
		w = int'(reg_width);
		if (w < MIN_DIM) w = MIN_DIM;
		if (w > TSP_MAX_WIDTH) w = TSP_MAX_WIDTH;
		h = int'(reg_height);
		if (h < MIN_DIM) h = MIN_DIM;
		r = int'(row_q);
		c = col_q;
		if (c > w - 1) c = w - 1;
		last_c = (c >= w - 1);
		last_r = (r >= h - 1);
		if (r == 0 && c == 0)
			removed_q = 1'b0;
		fg  = (v == 8'd0);
		top = line_mem[c];
		mid = line_mem[TSP_MAX_WIDTH + c];
		n = 0;
		res[0] = '0;
		res[1] = '0;
		// interior pixel one row up and one column left is now complete
		if (r >= 2 && c >= 2) begin
			nb  = {win_q[0], win_q[1], win_q[2], win_q[5], fg, mid, top, win_q[3]};
			pix = PIX_BG;
			if (win_q[4]) begin
				if (zs_removable(nb, reg_pass))
					removed_q = 1'b1;
				else
					pix = PIX_FG;
			end
			res[n] = mk_res(pix, 16'(r - 1), 10'(c - 1), 1'b0, 1'b0, 1'b0);
			n++;
		end
		if (r == 0 || last_r || c == 0 || last_c) begin
			res[n] = mk_res(fg ? PIX_FG : PIX_BG, 16'(r), 10'(c), 1'b0, last_r && last_c, 1'b0);
			n++;
		end
		for (int k = 0; k < n; k++)
			res[k].any_removed = removed_q;
		if (n > 0)
			res[n-1].last_of_run = 1'b1;
		line_mem[c] = mid;
		line_mem[TSP_MAX_WIDTH + c] = fg;
		win_q = {fg, mid, top, win_q[5:3]};
		if (last_c) begin
			col_q = 0;
			row_q = last_r ? 16'd0 : 16'(r + 1);
		end else begin
			col_q = c + 1;
			row_q = 16'(r);
		end
	endtask

	task automatic report_mismatch(input string field, input longint got, input longint want);
		$display("[%0t] %s: got %0d, expected %0d", $time, field, got, want);
		mismatches++;
	endtask

	task automatic check_result();
		tsp_result_t want;
		if (pix_expect_q.size() == 0) begin
			report_mismatch("unexpected output transaction, tdata", m_tdata, 0);
			return;
		end
		want = pix_expect_q.pop_front();
		if (m_tdata[7:0] !== want.pixel)
			report_mismatch("pixel_out", m_tdata[7:0], want.pixel);
		if (m_tdata[23:8] !== want.row)
			report_mismatch("out_row", m_tdata[23:8], want.row);
		if (m_tdata[33:24] !== want.col)
			report_mismatch("out_col", m_tdata[33:24], want.col);
		if (m_tdata[39:34] !== 6'd0)
			report_mismatch("tdata pad", m_tdata[39:34], 0);
		if (m_tlast !== want.last_of_run)
			report_mismatch("last_of_run", m_tlast, want.last_of_run);
		if (m_tuser[0] !== want.frame_end)
			report_mismatch("frame_end", m_tuser[0], want.frame_end);
		if (m_tuser[1] !== want.any_removed)
			report_mismatch("any_removed", m_tuser[1], want.any_removed);
	endtask

	// drain side: check accepted transactions, pick the next ready
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_result();
		m_tready <= arst_n && !rx_hold && (rx_pct == 0 || $urandom_range(99) >= rx_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// long receiver hold-off, so the unit fills up and stalls its input
	initial begin
		wait (hold_arm);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	task automatic send_pixel(input logic [7:0] v, input logic typed, input tsp_result_t want);
		tsp_result_t res [2];
		int          n;
		if (tx_pct > 0 && $urandom_range(99) < tx_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		do @(posedge clk); while (!s_tready);
		thin_predict(v, res, n);
		if (typed) begin
			pix_expect_q.push_back(want);
		end else begin
			for (int k = 0; k < n; k++)
				pix_expect_q.push_back(res[k]);
		end
		items_sent++;
	endtask

	// drop valid, wait for every expected result, then let the pipeline go quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pix_expect_q.size() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(input logic [10:0] w, input logic [15:0] h, input logic pk);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_wdata <= 16'(w);
		@(posedge clk);
		reg_width = w;
		cfg_index <= REG_IMAGE_HEIGHT;
		cfg_wdata <= h;
		@(posedge clk);
		reg_height = h;
		cfg_index <= REG_PASS_KIND;
		cfg_wdata <= 16'(pk);
		@(posedge clk);
		reg_pass = pk;
		cfg_wr_en <= 1'b0;
		frame_w = (w < MIN_DIM) ? MIN_DIM : ((w > TSP_MAX_WIDTH) ? TSP_MAX_WIDTH : int'(w));
		frame_h = (h < MIN_DIM) ? MIN_DIM : int'(h);
	endtask

	function automatic logic [7:0] bg_value();
		return ($urandom_range(3) == 0) ? PIX_BG : 8'($urandom_range(1, 255));
	endfunction

	// random-density frame, or a solid rectangle with a little noise
	task automatic send_frame(input bit rect);
		int density;
		int r0;
		int r1;
		int c0;
		int c1;
		bit fg;
		density = $urandom_range(20, 80);
		r0 = $urandom_range(0, frame_h - 1);
		r1 = $urandom_range(r0, frame_h - 1);
		c0 = $urandom_range(0, frame_w - 1);
		c1 = $urandom_range(c0, frame_w - 1);
		for (int r = 0; r < frame_h; r++) begin
			for (int c = 0; c < frame_w; c++) begin
				if (rect)
					fg = (r >= r0 && r <= r1 && c >= c0 && c <= c1) ^ ($urandom_range(19) == 0);
				else
					fg = ($urandom_range(99) < density);
				send_pixel(fg ? PIX_FG : bg_value(), 1'b0, '0);
			end
		end
	endtask

	initial begin
		idle_mode_t mode;
		int         phase;
		logic [10:0] raw_w;
		logic [15:0] raw_h;

		// 3x3, first pass: the centre has N, NW, W set and is removed
		dir_tab = '{
			'{8'd0,   1'b1, mk_res(PIX_FG, 16'd0, 10'd0, 1'b1, 1'b0, 1'b0)},
			'{8'd0,   1'b1, mk_res(PIX_FG, 16'd0, 10'd1, 1'b1, 1'b0, 1'b0)},
			'{8'd255, 1'b1, mk_res(PIX_BG, 16'd0, 10'd2, 1'b1, 1'b0, 1'b0)},
			'{8'd0,   1'b1, mk_res(PIX_FG, 16'd1, 10'd0, 1'b1, 1'b0, 1'b0)},
			'{8'd0,   1'b0, '0},
			'{8'd128, 1'b1, mk_res(PIX_BG, 16'd1, 10'd2, 1'b1, 1'b0, 1'b0)},
			'{8'd1,   1'b1, mk_res(PIX_BG, 16'd2, 10'd0, 1'b1, 1'b0, 1'b0)},
			'{8'd254, 1'b1, mk_res(PIX_BG, 16'd2, 10'd1, 1'b1, 1'b0, 1'b0)},
			'{8'd255, 1'b0, '0},
			// second pass: N, E and W set, so the centre is kept
			'{8'd0,   1'b0, '0},
			'{8'd0,   1'b0, '0},
			'{8'd0,   1'b0, '0},
			'{8'd0,   1'b0, '0},
			'{8'd0,   1'b0, '0},
			'{8'd0,   1'b0, '0},
			'{8'd7,   1'b0, '0},
			'{8'd200, 1'b0, '0},
			'{8'd255, 1'b0, '0}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		program_regs(11'd3, 16'd3, 1'b0);
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (i == 9) begin
				settle();
				program_regs(11'd3, 16'd3, 1'b1);
			end
			send_pixel(dir_tab[i].pix, dir_tab[i].typed, dir_tab[i].want);
		end

		items_sent = 0;
		phase = 0;
		while (items_sent < RANDOM_ITEMS) begin
			mode = idle_mode_t'(phase % 4);
			case (mode)
				IDLE_NONE: begin tx_pct = 0;  rx_pct = 0;  end
				IDLE_SEND: begin tx_pct = 51; rx_pct = 0;  end
				IDLE_RECV: begin tx_pct = 0;  rx_pct = 51; end
				default:   begin tx_pct = 19; rx_pct = 19; end
			endcase
			case ($urandom_range(9))
				0:       raw_w = 11'($urandom_range(0, 2));
				9:       raw_w = 11'($urandom_range(13, 40));
				default: raw_w = 11'($urandom_range(3, 12));
			endcase
			raw_h = ($urandom_range(9) == 0) ? 16'($urandom_range(0, 2))
				: 16'($urandom_range(3, 10));
			if (phase == 1) begin
				raw_w = 11'd0;
				raw_h = 16'd0;
			end
			settle();
			program_regs(raw_w, raw_h, 1'($urandom_range(1)));
			if (phase == 4)
				hold_arm = 1'b1;
			for (int f = $urandom_range(1, 3); f > 0; f--)
				send_frame(1'($urandom_range(1)));
			// broken frame: a partial row leaves the counters mid-frame
			if ($urandom_range(3) == 0) begin
				for (int k = $urandom_range(1, frame_w); k > 0; k--)
					send_pixel(($urandom_range(1) != 0) ? PIX_FG : bg_value(), 1'b0, '0);
			end
			phase++;
		end

		// widest and tallest setting: the start of a row far wider than any random frame
		tx_pct = 0;
		rx_pct = 0;
		settle();
		program_regs(11'd2047, 16'd65535, 1'b1);
		for (int k = 0; k < WIDE_ITEMS; k++)
			send_pixel(($urandom_range(1) != 0) ? PIX_FG : bg_value(), 1'b0, '0);

		settle();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
